/* sv/scan_cluster_midpoint_obstacles_macros.svh */
// Assertion helpers; the using module provides clk and rst_n.
`ifndef SCAN_CLUSTER_MIDPOINT_OBSTACLES_MACROS_SVH
`define SCAN_CLUSTER_MIDPOINT_OBSTACLES_MACROS_SVH

// same-cycle implication
`define SCM_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("scm assertion failed");

// next-cycle implication
`define SCM_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("scm assertion failed");

`endif

/* sv/scm_pkg.sv */
package scm_pkg;

  localparam int MAX_SAMPLES  = 4096;
  localparam int CORDIC_STEPS = 16;
  localparam int SCNT_W       = $clog2(MAX_SAMPLES) + 1;
  localparam int ITER_W       = $clog2(CORDIC_STEPS);

  localparam int RANGE_W = 16;
  localparam int IDX_W   = 12;
  localparam int LEN_W   = 13;
  localparam int COORD_W = 17;
  localparam int XW      = 35;  // CORDIC x/y
  localparam int ZW      = 34;  // CORDIC residual angle
  localparam int PW      = 36;  // scaled point
  localparam int ATAN_W  = 30;

  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam int          COORD_LIMIT  = 65535;

  localparam logic [15:0] JOIN_RST    = 16'd100;
  localparam logic [12:0] MIN_LEN_RST = 13'd15;
  localparam logic [12:0] MAX_LEN_RST = 13'd100;

  localparam logic [2:0] CFG_JOIN      = 3'd0;
  localparam logic [2:0] CFG_START_ANG = 3'd1;
  localparam logic [2:0] CFG_ANG_STEP  = 3'd2;
  localparam logic [2:0] CFG_MIN_LEN   = 3'd3;
  localparam logic [2:0] CFG_MAX_LEN   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ANGLE,
    S_INIT,
    S_ROT,
    S_MUL,
    S_FIN
  } state_t;

  typedef struct packed {
    logic              accept;
    logic              ang_load;
    logic              rot_init;
    logic              rot_step;
    logic              mul_en;
    logic [1:0]        mul_k;
    logic [ITER_W-1:0] iter;
    logic              pt;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic report;
    logic out_free;
  } status_t;

  // atan(2^-i) in binary angle units
  function automatic logic [ATAN_W-1:0] atan_of(input logic [4:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:    v = 30'h20000000;
      5'd1:    v = 30'h12E4051E;
      5'd2:    v = 30'h09FB385B;
      5'd3:    v = 30'h051111D4;
      5'd4:    v = 30'h028B0D43;
      5'd5:    v = 30'h0145D7E1;
      5'd6:    v = 30'h00A2F61E;
      5'd7:    v = 30'h00517C55;
      5'd8:    v = 30'h0028BE53;
      5'd9:    v = 30'h00145F2F;
      5'd10:   v = 30'h000A2F98;
      5'd11:   v = 30'h000517CC;
      5'd12:   v = 30'h00028BE6;
      5'd13:   v = 30'h000145F3;
      5'd14:   v = 30'h0000A2FA;
      5'd15:   v = 30'h0000517D;
      5'd16:   v = 30'h000028BE;
      5'd17:   v = 30'h0000145F;
      5'd18:   v = 30'h00000A30;
      5'd19:   v = 30'h00000518;
      5'd20:   v = 30'h0000028C;
      5'd21:   v = 30'h00000146;
      5'd22:   v = 30'h000000A3;
      5'd23:   v = 30'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* sv/scm_if.sv */
interface scm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_mm;
  logic        scan_end;
  modport source (output valid, range_mm, scan_end, input ready);
  modport sink (input valid, range_mm, scan_end, output ready);
endinterface

interface scm_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] obstacle_x;
  logic signed [16:0] obstacle_y;
  logic        [11:0] cluster_number;
  modport source (output valid, obstacle_x, obstacle_y, cluster_number, input ready);
  modport sink (input valid, obstacle_x, obstacle_y, cluster_number, output ready);
endinterface

/* sv/scm_ctrl.sv */
`include "scan_cluster_midpoint_obstacles_macros.svh"

module scm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  scm_pkg::status_t st,
  output scm_pkg::cmd_t    cmd
);

  localparam logic [scm_pkg::ITER_W-1:0] LAST = scm_pkg::ITER_W'(scm_pkg::CORDIC_STEPS - 1);

  scm_pkg::state_t state_r, state_nxt;
  logic [scm_pkg::ITER_W-1:0] iter_r, iter_nxt;
  logic [1:0] mul_r, mul_nxt;
  logic pt_r, pt_nxt;
  logic in_fire;

  assign in_ready = (state_r == scm_pkg::S_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scm_pkg::S_IDLE;
      iter_r  <= '0;
      mul_r   <= '0;
      pt_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
      mul_r   <= mul_nxt;
      pt_r    <= pt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    mul_nxt   = mul_r;
    pt_nxt    = pt_r;
    case (state_r)
      scm_pkg::S_IDLE: begin
        if (in_fire && st.report) begin
          state_nxt = scm_pkg::S_ANGLE;
          pt_nxt    = 1'b0;
        end
      end
      scm_pkg::S_ANGLE: state_nxt = scm_pkg::S_INIT;
      scm_pkg::S_INIT: begin
        state_nxt = scm_pkg::S_ROT;
        iter_nxt  = '0;
      end
      scm_pkg::S_ROT: begin
        if (iter_r == LAST) begin
          state_nxt = scm_pkg::S_MUL;
          mul_nxt   = '0;
        end else begin
          iter_nxt = iter_r + 1'b1;
        end
      end
      scm_pkg::S_MUL: begin
        if (mul_r == 2'd3) begin
          if (pt_r) begin
            state_nxt = scm_pkg::S_FIN;
          end else begin
            pt_nxt    = 1'b1;
            state_nxt = scm_pkg::S_ANGLE;
          end
        end else begin
          mul_nxt = mul_r + 1'b1;
        end
      end
      scm_pkg::S_FIN: begin
        if (st.out_free) state_nxt = scm_pkg::S_IDLE;
      end
      default: state_nxt = scm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.accept   = in_fire;
    cmd.ang_load = (state_r == scm_pkg::S_ANGLE);
    cmd.rot_init = (state_r == scm_pkg::S_INIT);
    cmd.rot_step = (state_r == scm_pkg::S_ROT);
    cmd.mul_en   = (state_r == scm_pkg::S_MUL);
    cmd.mul_k    = mul_r;
    cmd.iter     = iter_r;
    cmd.pt       = pt_r;
    cmd.out_load = (state_r == scm_pkg::S_FIN) && st.out_free;
  end

  `SCM_ASSERT_NXT(a_report_starts_job, in_fire && st.report, state_r == scm_pkg::S_ANGLE)
  `SCM_ASSERT_NXT(a_plain_beat_stays_idle, in_fire && !st.report, state_r == scm_pkg::S_IDLE)
  `SCM_ASSERT_NXT(a_rot_ends_in_mul, state_r == scm_pkg::S_ROT && iter_r == LAST, state_r == scm_pkg::S_MUL && mul_r == 2'd0)

endmodule

/* sv/scm_dp.sv */
module scm_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_wdata,
  input  logic [15:0]      in_range_mm,
  input  logic             in_scan_end,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [16:0]      out_x,
  output logic [16:0]      out_y,
  output logic [11:0]      out_num,
  input  scm_pkg::cmd_t    cmd,
  output scm_pkg::status_t st
);

  localparam int RW = scm_pkg::RANGE_W;
  localparam int IW = scm_pkg::IDX_W;
  localparam int LW = scm_pkg::LEN_W;
  localparam int XW = scm_pkg::XW;
  localparam int ZW = scm_pkg::ZW;
  localparam int PW = scm_pkg::PW;

  // configuration
  logic [15:0] join_r;
  logic [31:0] start_ang_r;
  logic [25:0] ang_step_r;
  logic [12:0] min_len_r, max_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      join_r      <= scm_pkg::JOIN_RST;
      start_ang_r <= '0;
      ang_step_r  <= '0;
      min_len_r   <= scm_pkg::MIN_LEN_RST;
      max_len_r   <= scm_pkg::MAX_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        scm_pkg::CFG_JOIN:      join_r      <= cfg_wdata[15:0];
        scm_pkg::CFG_START_ANG: start_ang_r <= cfg_wdata;
        scm_pkg::CFG_ANG_STEP:  ang_step_r  <= cfg_wdata[25:0];
        scm_pkg::CFG_MIN_LEN:   min_len_r   <= cfg_wdata[12:0];
        scm_pkg::CFG_MAX_LEN:   max_len_r   <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  // cluster tracking
  logic                      open_r, open_nxt;
  logic [RW-1:0]             prev_r, prev_nxt, first_r, first_nxt;
  logic [IW-1:0]             fidx_r, fidx_nxt, closed_r, closed_nxt;
  logic [LW-1:0]             run_r, run_nxt;
  logic [scm_pkg::SCNT_W-1:0] scnt_r, scnt_nxt;
  logic [RW-1:0]             diff;
  logic                      report;

  always_comb begin
    open_nxt   = open_r;
    prev_nxt   = prev_r;
    first_nxt  = first_r;
    fidx_nxt   = fidx_r;
    closed_nxt = closed_r;
    run_nxt    = run_r;
    scnt_nxt   = scnt_r;
    report     = 1'b0;
    diff = (in_range_mm > prev_r) ? in_range_mm - prev_r : prev_r - in_range_mm;
    if (scnt_r < scm_pkg::SCNT_W'(scm_pkg::MAX_SAMPLES)) begin
      if (!open_r || diff > join_r) begin
        if (open_r) begin
          report = (prev_r <= in_range_mm) && (run_r >= min_len_r) && (run_r <= max_len_r);
          closed_nxt = closed_r + 1'b1;
        end
        open_nxt  = 1'b1;
        first_nxt = in_range_mm;
        prev_nxt  = in_range_mm;
        fidx_nxt  = IW'(scnt_r);
        run_nxt   = LW'(1);
      end else begin
        if (run_r != {LW{1'b1}}) run_nxt = run_r + 1'b1;
        prev_nxt = in_range_mm;
      end
      scnt_nxt = scnt_r + 1'b1;
    end
    if (in_scan_end) begin
      open_nxt   = 1'b0;
      prev_nxt   = '0;
      first_nxt  = '0;
      fidx_nxt   = '0;
      run_nxt    = '0;
      scnt_nxt   = '0;
      closed_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r   <= 1'b0;
      prev_r   <= '0;
      first_r  <= '0;
      fidx_r   <= '0;
      run_r    <= '0;
      scnt_r   <= '0;
      closed_r <= '0;
    end else if (cmd.accept) begin
      open_r   <= open_nxt;
      prev_r   <= prev_nxt;
      first_r  <= first_nxt;
      fidx_r   <= fidx_nxt;
      run_r    <= run_nxt;
      scnt_r   <= scnt_nxt;
      closed_r <= closed_nxt;
    end
  end

  // job capture for a reported cluster
  logic [RW-1:0] j_r0_r, j_r1_r;
  logic [IW-1:0] j_i0_r, j_i1_r, j_num_r;

  always_ff @(posedge clk) begin
    if (cmd.accept && report) begin
      j_r0_r  <= first_r;
      j_r1_r  <= prev_r;
      j_i0_r  <= fidx_r;
      j_i1_r  <= fidx_r + IW'(run_r - 1'b1);
      j_num_r <= closed_r;
    end
  end

  // sample angle
  logic signed [25:0]   step_s;
  logic signed [38:0]   ang_prod;
  logic [IW-1:0]        idx;
  logic [31:0]          ang_r;

  assign idx      = cmd.pt ? j_i1_r : j_i0_r;
  assign step_s   = ang_step_r;
  assign ang_prod = step_s * $signed({1'b0, idx});

  always_ff @(posedge clk) begin
    if (cmd.ang_load) ang_r <= start_ang_r + ang_prod[31:0];
  end

  // iterative CORDIC
  logic signed [XW-1:0] x_r, y_r, x0, dx, dy;
  logic signed [ZW-1:0] z_r, at;
  logic                 fold;
  logic [31:0]          ang_f;
  logic [RW-1:0]        rsel;

  assign rsel  = cmd.pt ? j_r1_r : j_r0_r;
  assign fold  = ang_r[31] ^ ang_r[30];
  assign ang_f = fold ? {~ang_r[31], ang_r[30:0]} : ang_r;
  assign x0    = $signed({3'b000, rsel, 16'h0000});
  assign dx    = y_r >>> cmd.iter;
  assign dy    = x_r >>> cmd.iter;
  assign at    = $signed({4'b0000, scm_pkg::atan_of(5'(cmd.iter))});

  always_ff @(posedge clk) begin
    if (cmd.rot_init) begin
      x_r <= fold ? -x0 : x0;
      y_r <= '0;
      z_r <= ZW'($signed(ang_f));
    end else if (cmd.rot_step) begin
      if (!z_r[ZW-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
  end

  // gain correction, one 18x31 product per cycle: low half then high half
  logic signed [XW-1:0] msrc;
  logic signed [17:0]   mop;
  logic signed [48:0]   mprod, acc_r;
  logic signed [65:0]   full;
  logic signed [PW-1:0] pres;
  logic signed [PW-1:0] xs_r, ys_r, xe_r, ye_r;

  assign msrc  = cmd.mul_k[1] ? y_r : x_r;
  assign mop   = cmd.mul_k[0] ? $signed(msrc[34:17]) : $signed({1'b0, msrc[16:0]});
  assign mprod = mop * $signed({1'b0, scm_pkg::INV_GAIN_Q30});
  assign full  = (66'(mprod) <<< 17) + 66'(acc_r);
  assign pres  = PW'(full >>> 30);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      if (!cmd.mul_k[0]) begin
        acc_r <= mprod;
      end else begin
        case ({cmd.pt, cmd.mul_k[1]})
          2'b00:   xs_r <= pres;
          2'b01:   ys_r <= pres;
          2'b10:   xe_r <= pres;
          default: ye_r <= pres;
        endcase
      end
    end
  end

  // floored midpoint with saturation
  function automatic logic [16:0] mid(input logic signed [PW-1:0] a,
                                      input logic signed [PW-1:0] b);
    logic signed [PW:0]   s;
    logic signed [PW-17:0] m;
    logic [16:0]          v;
    s = (PW+1)'(a) + (PW+1)'(b);
    m = (PW-16)'(s >>> 17);
    if (m > (PW-16)'(scm_pkg::COORD_LIMIT)) v = 17'(scm_pkg::COORD_LIMIT);
    else if (m < -(PW-16)'(scm_pkg::COORD_LIMIT)) v = -17'(scm_pkg::COORD_LIMIT);
    else v = m[16:0];
    return v;
  endfunction

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_x   <= mid(xs_r, xe_r);
      out_y   <= mid(ys_r, ye_r);
      out_num <= j_num_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign st.report   = report;
  assign st.out_free = !out_valid_r || out_ready;

endmodule

/* sv/scan_cluster_midpoint_obstacles.sv */
// Lidar scan segmenter: one range sample per input beat. A sample that neither closes a
// reportable cluster nor is refused leaves the block ready for the next sample. A sample
// that closes a cluster meeting the report rules starts a job during which input is held
// off, longer while the previous result still waits unaccepted: two polar-to-cartesian
// conversions on one iterative CORDIC unit, one micro-rotation per cycle, each followed by
// gain correction on a single 18x31 multiplier (low then high half of x, then of y), then
// a hand-off of the result to the output register. The result waits there, so the next
// sample is taken while it is still pending. Configuration writes take effect at once.
module scan_cluster_midpoint_obstacles (
  input  logic        clk,
  input  logic        rst_n,
  scm_in_if.sink      in_bus,
  scm_out_if.source   out_bus,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  scm_pkg::cmd_t    cmd;
  scm_pkg::status_t st;
  logic [16:0]      ox, oy;

  scm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .st       (st),
    .cmd      (cmd)
  );

  scm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_range_mm (in_bus.range_mm),
    .in_scan_end (in_bus.scan_end),
    .out_ready   (out_bus.ready),
    .out_valid   (out_bus.valid),
    .out_x       (ox),
    .out_y       (oy),
    .out_num     (out_bus.cluster_number),
    .cmd         (cmd),
    .st          (st)
  );

  assign out_bus.obstacle_x = $signed(ox);
  assign out_bus.obstacle_y = $signed(oy);

endmodule

/* verif/scm_test_if.sv */
`timescale 1ns / 100ps

// Channel interfaces come with the RTL (sv/scm_if.sv); nothing extra is needed here.
package scm_test_pkg;
  localparam int SETTLE_CYCLES = 60;
endpackage

/* verif/scan_cluster_midpoint_obstacles_test.sv */
`timescale 1ns / 100ps

module scan_cluster_midpoint_obstacles_test;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_wdata;

  scm_in_if in_bus();
  scm_out_if out_bus();

  scan_cluster_midpoint_obstacles uut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus), .out_bus(out_bus),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic [11:0] num;
  } obstacle_t;

  // predictor state
  logic [15:0] thr;
  logic [31:0] ang0;
  logic [25:0] dang;
  logic [12:0] len_lo, len_hi;
  bit          open_q;
  logic [15:0] prev_r, first_r;
  logic [11:0] first_idx, n_closed;
  logic [12:0] run_len, n_samples;

  obstacle_t pending_obstacles[$];
  int errors, n_items, n_reports;
  bit quiet;
  longint cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("timeout at %0t", $time);
      $display("status: fail");
      $finish;
    end
  end

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void to_xy(input logic [15:0] r, input logic [31:0] a,
                                output longint px, output longint py);
    longint x, y, z, dx, dy, t;
    x = longint'(r) * 65536;
    y = 0;
    if (a[31] ^ a[30]) begin
      a[31] = ~a[31];
      x = -x;
    end
    z = longint'($signed(a));
    for (int i = 0; i < scm_pkg::CORDIC_STEPS && i < 24; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      t = longint'(scm_pkg::atan_of(i[4:0]));
      if (z >= 0) begin
        x -= dx; y += dy; z -= t;
      end else begin
        x += dx; y -= dy; z += t;
      end
    end
    px = fshift(x * 652032874, 30);
    py = fshift(y * 652032874, 30);
  endfunction

  function automatic logic [16:0] mid(longint a, longint b);
    longint m;
    m = fshift(a + b, 17);
    if (m > 65535) m = 65535;
    if (m < -65535) m = -65535;
    return m[16:0];
  endfunction

  function automatic logic [31:0] angle_at(logic [11:0] idx);
    logic [31:0] st;
    st = {{6{dang[25]}}, dang};
    return ang0 + st * {20'd0, idx};
  endfunction

  function automatic void clear_scan();
    open_q = 0; prev_r = 0; first_r = 0; first_idx = 0;
    run_len = 0; n_samples = 0; n_closed = 0;
  endfunction

  function automatic void start_cluster(logic [15:0] r);
    open_q = 1; first_r = r; prev_r = r; first_idx = n_samples[11:0]; run_len = 1;
  endfunction

  function automatic void predict_sample(logic [15:0] r, bit last);
    logic [15:0] diff;
    longint xs, ys, xe, ye;
    obstacle_t o;
    if (n_samples < scm_pkg::MAX_SAMPLES) begin
      if (!open_q) start_cluster(r);
      else begin
        diff = (r > prev_r) ? r - prev_r : prev_r - r;
        if (diff <= thr) begin
          if (run_len < 13'h1FFF) run_len++;
          prev_r = r;
        end else begin
          if (prev_r <= r && run_len >= len_lo && run_len <= len_hi) begin
            to_xy(first_r, angle_at(first_idx), xs, ys);
            to_xy(prev_r, angle_at(first_idx + run_len[11:0] - 12'd1), xe, ye);
            o.x = mid(xs, xe);
            o.y = mid(ys, ye);
            o.num = n_closed;
            pending_obstacles.insert(pending_obstacles.size(), o);
          end
          n_closed++;
          start_cluster(r);
        end
      end
      n_samples++;
    end
    if (last) clear_scan();
  endfunction

  // result side: random stall bursts, checked against oldest expectation
  initial begin
    int stall;
    obstacle_t e;
    out_bus.ready <= 0;
    @(posedge clk iff rst_n);
    forever begin
      stall = quiet ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
      if (stall > 0) begin
        out_bus.ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1;
      @(posedge clk);
      if (out_bus.valid && out_bus.ready) begin
        n_reports++;
        if (pending_obstacles.size() == 0) begin
          errors++;
          $display("%0t unexpected beat x=%0d y=%0d n=%0d", $time,
                   out_bus.obstacle_x, out_bus.obstacle_y, out_bus.cluster_number);
        end else begin
          e = pending_obstacles.pop_front();
          if (e.x !== out_bus.obstacle_x || e.y !== out_bus.obstacle_y ||
              e.num !== out_bus.cluster_number) begin
            errors++;
            $display("%0t mismatch exp x=%0d y=%0d n=%0d got x=%0d y=%0d n=%0d", $time,
                     e.x, e.y, e.num, out_bus.obstacle_x, out_bus.obstacle_y,
                     out_bus.cluster_number);
          end
        end
      end
    end
  end

  // valid stays high after the beat; drain() drops it at the end of a burst
  task automatic send_sample(logic [15:0] r, bit last);
    int gap;
    gap = quiet ? 0 : (($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0);
    if (gap > 0) begin
      in_bus.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1;
    in_bus.range_mm <= r;
    in_bus.scan_end <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predict_sample(r, last);
    n_items++;
  endtask

  task automatic drain();
    in_bus.valid <= 0;
    while (pending_obstacles.size() != 0) @(posedge clk);
    repeat (scm_test_pkg::SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      scm_pkg::CFG_JOIN:      thr = v[15:0];
      scm_pkg::CFG_START_ANG: ang0 = v;
      scm_pkg::CFG_ANG_STEP:  dang = v[25:0];
      scm_pkg::CFG_MIN_LEN:   len_lo = v[12:0];
      scm_pkg::CFG_MAX_LEN:   len_hi = v[12:0];
      default: ;
    endcase
  endtask

  task automatic setup(logic [15:0] j, logic [31:0] a0, logic [25:0] da,
                       logic [12:0] lo, logic [12:0] hi);
    drain();
    write_reg(scm_pkg::CFG_JOIN, {16'd0, j});
    write_reg(scm_pkg::CFG_START_ANG, a0);
    write_reg(scm_pkg::CFG_ANG_STEP, {{6{da[25]}}, da});
    write_reg(scm_pkg::CFG_MIN_LEN, {19'd0, lo});
    write_reg(scm_pkg::CFG_MAX_LEN, {19'd0, hi});
    cfg_we <= 0;
  endtask

  // a cluster of roughly flat samples near base
  task automatic send_cluster(int len, logic [15:0] base, logic [15:0] jit);
    for (int i = 0; i < len; i++)
      send_sample(16'(base + $urandom_range(0, jit)), 1'b0);
  endtask

  task automatic test_reset_defaults();
    // near cluster then far jump: reported with reset limits
    send_cluster(20, 16'd1000, 16'd0);
    send_sample(16'd5000, 1'b0);
    send_cluster(3, 16'd5000, 16'd0);
    send_sample(16'd200, 1'b1);
  endtask

  task automatic test_extremes();
    setup(16'd0, 32'h7FFF_FFFF, 26'h100_0000, 13'd1, 13'd1);
    send_sample(16'd65535, 1'b0);
    send_sample(16'd0, 1'b0);
    send_sample(16'd65535, 1'b0);
    send_sample(16'd65535, 1'b0);
    send_sample(16'd1, 1'b1);
    setup(16'hFFFF, 32'h8000_0000, 26'h300_0000, 13'd1, 13'd4096);
    send_sample(16'd0, 1'b0);
    send_sample(16'd65535, 1'b1);
    // crossed limits: nothing reported
    setup(16'd10, 32'h4000_0000, 26'd0, 13'd5, 13'd2);
    send_cluster(3, 16'd100, 16'd0);
    send_sample(16'd900, 1'b0);
    send_sample(16'd900, 1'b1);
    // equal range closing, closing on scan end
    setup(16'd5, 32'hC000_0000, 26'h3FF_FFFF, 13'd2, 13'd3);
    send_cluster(2, 16'd300, 16'd0);
    send_sample(16'd400, 1'b0);
    send_sample(16'd400, 1'b0);
    send_sample(16'd500, 1'b1);
  endtask

  task automatic test_random_scans();
    int len;
    for (int p = 0; p < 6; p++) begin
      setup($urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(5, 200)),
            $urandom, 26'($urandom_range(0, 32'h0200_0000) - 32'h0100_0000),
            13'($urandom_range(1, 6)), 13'($urandom_range(3, 30)));
      for (int s = 0; s < 5; s++) begin
        for (int c = 0; c < $urandom_range(2, 8); c++) begin
          len = $urandom_range(1, 12);
          if ($urandom_range(0, 9) == 0) send_sample(16'($urandom), 1'b0);
          else send_cluster(len, 16'($urandom_range(0, 60000)), 16'($urandom_range(0, 8)));
        end
        send_sample(16'($urandom), 1'b1);
      end
    end
  endtask

  task automatic test_quiet_tail();
    quiet = 1;
    setup(16'd20, 32'h2000_0000, 26'h001_0000, 13'd1, 13'd10);
    for (int c = 0; c < 20; c++)
      send_cluster($urandom_range(1, 6), 16'($urandom_range(0, 65535)), 16'd3);
    send_sample(16'd0, 1'b1);
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0; cfg_index = scm_pkg::CFG_JOIN; cfg_wdata = 0;
    in_bus.valid = 0; in_bus.range_mm = 0; in_bus.scan_end = 0;
    errors = 0; n_items = 0; n_reports = 0; quiet = 0; cycles = 0;
    thr = scm_pkg::JOIN_RST; ang0 = 0; dang = 0;
    len_lo = scm_pkg::MIN_LEN_RST; len_hi = scm_pkg::MAX_LEN_RST;
    clear_scan();
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_reset_defaults();
    test_extremes();
    test_random_scans();
    test_quiet_tail();
    drain();
    $display("covered %0d samples, %0d obstacle reports, directed and random scans",
             n_items, n_reports);
    if (errors == 0 && pending_obstacles.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
